### rtl/nidv_pkg.sv
// Shared types, constants and helpers for the national ID number validator.
`timescale 1ns / 1ps
`default_nettype none

package nidv_pkg;

  // Transaction opcodes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Verdict codes
  localparam logic [2:0] VERDICT_INVALID = 3'd0;
  localparam logic [2:0] VERDICT_MALE    = 3'd1;
  localparam logic [2:0] VERDICT_FEMALE  = 3'd2;
  localparam logic [2:0] VERDICT_DONE    = 3'd3;
  localparam logic [2:0] VERDICT_FULL    = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_MIN_YEAR = 1'b0;
  localparam logic REG_MAX_YEAR = 1'b1;

  localparam int unsigned NUM_DIGITS = 17;
  localparam int unsigned DIGITS_W   = 4 * NUM_DIGITS;
  localparam int unsigned YEAR_W     = 14;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2011;

  localparam logic [3:0] DIGIT_WEIGHT [NUM_DIGITS] =
    '{4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2, 4'd1, 4'd6,
      4'd3, 4'd7, 4'd9, 4'd10, 4'd5, 4'd8, 4'd4, 4'd2};

  // check character per residue; 10 stands for X
  localparam logic [3:0] CHECK_CODE [11] =
    '{4'd1, 4'd0, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};

  localparam logic [4:0] MONTH_DAYS [12] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Status of the digit unit
  typedef struct packed {
    logic              busy;
    logic              bad;      // some nibble above 9
    logic [3:0]        residue;  // weighted sum mod 11
    logic [YEAR_W-1:0] year;
  } nidv_dig_sts_t;

  // Residue of a value below 176 modulo 11 by conditional subtraction
  function automatic logic [3:0] mod11_reduce(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd88) t = t - 8'd88;
    if (t >= 8'd44) t = t - 8'd44;
    if (t >= 8'd22) t = t - 8'd22;
    if (t >= 8'd11) t = t - 8'd11;
    return t[3:0];
  endfunction

  // Two decimal digits times ten plus units
  function automatic logic [6:0] bcd2_value(input logic [3:0] tens, input logic [3:0] units);
    return 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(units);
  endfunction

  // Two-digit decimal number divisible by 4
  function automatic logic div4(input logic [3:0] tens, input logic [3:0] units);
    if (tens[0]) return (units == 4'd2) || (units == 4'd6);
    else return (units == 4'd0) || (units == 4'd4) || (units == 4'd8);
  endfunction

  // Gregorian leap year from the four year digits
  function automatic logic leap_year(input logic [3:0] d0, input logic [3:0] d1,
                                     input logic [3:0] d2, input logic [3:0] d3);
    logic century;
    century = (d2 == 4'd0) && (d3 == 4'd0);
    return (div4(d2, d3) && !century) || (century && div4(d0, d1));
  endfunction

endpackage

`default_nettype wire

### rtl/nidv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nidv_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/nidv_dig.sv
// Digit unit: one BCD digit per cycle through a shared multiply-accumulate mod 11.
`timescale 1ns / 1ps
`default_nettype none

module nidv_dig
  import nidv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DIGITS_W-1:0] digits_i,
  output nidv_dig_sts_t            sts_o
);

  logic [DIGITS_W-1:0] sh_q, sh_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                bad_q, bad_d;
  logic [3:0]          res_q, res_d;
  logic [YEAR_W-1:0]   year_q, year_d;

  logic [3:0] digit;
  logic [7:0] prod;
  logic [7:0] acc;

  assign digit = sh_q[DIGITS_W-1 -: 4];
  assign prod  = {4'b0, digit} * {4'b0, DIGIT_WEIGHT[cnt_q]};
  assign acc   = prod + {4'b0, res_q};

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    bad_d  = bad_q;
    res_d  = res_q;
    year_d = year_q;
    if (start_i) begin
      sh_d   = digits_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
      bad_d  = 1'b0;
      res_d  = 4'd0;
      year_d = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[DIGITS_W-5:0], 4'b0};
      cnt_d = cnt_q + 5'd1;
      res_d = mod11_reduce(acc);
      if (digit > 4'd9) bad_d = 1'b1;
      // year digits sit at places 6..9
      if (cnt_q >= 5'd6 && cnt_q <= 5'd9) begin
        year_d = YEAR_W'({3'b0, year_q, 3'b0} + {5'b0, year_q, 1'b0} + 20'(digit));
      end
      if (cnt_q == 5'(NUM_DIGITS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    bad_q  <= bad_d;
    res_q  <= res_d;
    year_q <= year_d;
  end

  assign sts_o.busy    = busy_q;
  assign sts_o.bad     = bad_q;
  assign sts_o.residue = res_q;
  assign sts_o.year    = year_q;

endmodule

`default_nettype wire

### rtl/national_id_number_validator.sv
// Top level: resident ID number validator with a region code table.
//
// Input channel (valid/ready): one transaction carries opcode, region, birth
// date, sequence and check character. Add stores a region code, check tests
// an ID, clear empties the table. Output channel (valid/ready): one verdict
// per input transaction, in order.
// Add scans the table for duplicates and check scans it for the region code,
// one entry per cycle; clear and unused opcodes skip the scan. For check the
// scan runs beside the digit unit, which takes one digit per cycle for 17
// digits.
// The block takes one transaction at a time; in_ready_o is high only while
// the sequencer is idle, so the next accept comes in the same cycle as the
// verdict turns valid at the earliest.
// The number of stored region codes sets the scan length.
// A finished verdict waits in the output register; the next transaction may
// be accepted meanwhile, and a stalled receiver holds the sequencer only when
// a second verdict is ready. Reset empties the table (count to zero, no
// clearing pass) and loads the year limits 1900 and 2011.
// Configuration: APB, min_year at 0x0, max_year at 0x4, write while idle.
`timescale 1ns / 1ps
`default_nettype none

module national_id_number_validator
  import nidv_pkg::*;
#(
  parameter int unsigned REGION_SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [23:0] region_digits_i,
  input  wire logic [31:0] birth_date_digits_i,
  input  wire logic [11:0] sequence_digits_i,
  input  wire logic [3:0]  check_char_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       verdict_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CNT_W = $clog2(REGION_SLOTS + 1);
  localparam int unsigned AW    = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  opcode_q;
  logic [23:0] region_q;
  logic [31:0] date_q;
  logic [11:0] seq_q;
  logic [3:0]  chk_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             pend_q, pend_d;
  logic             found_q, found_d;

  logic [YEAR_W-1:0] min_year_q, max_year_q;

  logic       out_valid_q, out_valid_d;
  logic [2:0] verdict_q, verdict_d;

  logic          in_acc;
  logic          cfg_wr;
  logic          ram_we;
  logic [23:0]   ram_rdata;
  nidv_dig_sts_t dig_sts;
  logic [2:0]    check_verdict;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MIN_YEAR_RST;
      max_year_q <= MAX_YEAR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_YEAR: min_year_q <= pwdata[YEAR_W-1:0];
        REG_MAX_YEAR: max_year_q <= pwdata[YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_YEAR: prdata = {18'b0, min_year_q};
      REG_MAX_YEAR: prdata = {18'b0, max_year_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- units
  nidv_ram #(
    .WIDTH (24),
    .DEPTH (REGION_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (region_q),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  nidv_dig u_dig (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && (opcode_i == OP_CHECK)),
    .digits_i ({region_digits_i, birth_date_digits_i, sequence_digits_i}),
    .sts_o    (dig_sts)
  );

  // ---------------------------------------------------------------- check verdict
  always_comb begin
    logic [6:0] month;
    logic [6:0] day;
    logic [4:0] limit;
    logic       ok;
    month = bcd2_value(date_q[15:12], date_q[11:8]);
    day   = bcd2_value(date_q[7:4], date_q[3:0]);
    limit = 5'd31;
    ok    = !dig_sts.bad && found_q;
    if (dig_sts.year < min_year_q || dig_sts.year > max_year_q) ok = 1'b0;
    if (month < 7'd1 || month > 7'd12) begin
      ok = 1'b0;
    end else begin
      limit = MONTH_DAYS[4'(month - 7'd1)];
      if (month == 7'd2 &&
          leap_year(date_q[31:28], date_q[27:24], date_q[23:20], date_q[19:16])) begin
        limit = 5'd29;
      end
    end
    if (day < 7'd1 || day > {2'b0, limit}) ok = 1'b0;
    if (seq_q == 12'h000) ok = 1'b0;
    if (dig_sts.residue > 4'd10) begin
      ok = 1'b0;
    end else if (chk_q != CHECK_CODE[dig_sts.residue]) begin
      ok = 1'b0;
    end
    if (!ok)           check_verdict = VERDICT_INVALID;
    else if (seq_q[0]) check_verdict = VERDICT_MALE;
    else               check_verdict = VERDICT_FEMALE;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    found_d     = found_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          scan_d  = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          if (opcode_i == OP_ADD || opcode_i == OP_CHECK) state_d = S_SCAN;
          else state_d = S_EVAL;
        end
      end
      S_SCAN: begin
        // one table read issued per cycle, compared in the next cycle
        if (pend_q && ram_rdata == region_q) found_d = 1'b1;
        if (scan_q != count_q) begin
          scan_d = scan_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!dig_sts.busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (opcode_q)
            OP_ADD: begin
              if (found_q) begin
                verdict_d = VERDICT_DONE;
              end else if (count_q == CNT_W'(REGION_SLOTS)) begin
                verdict_d = VERDICT_FULL;
              end else begin
                ram_we    = 1'b1;
                count_d   = count_q + CNT_W'(1);
                verdict_d = VERDICT_DONE;
              end
            end
            OP_CHECK: verdict_d = check_verdict;
            OP_CLEAR: begin
              count_d   = '0;
              verdict_d = VERDICT_DONE;
            end
            default: verdict_d = VERDICT_INVALID;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    if (in_acc) begin
      opcode_q <= opcode_i;
      region_q <= region_digits_i;
      date_q   <= birth_date_digits_i;
      seq_q    <= sequence_digits_i;
      chk_q    <= check_char_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

`default_nettype wire

### rtl/nidv_sva.sv
// Port-level assertion checker for the validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nidv_sva
  import nidv_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  opcode_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  verdict_o
);

  // verdict is always a defined code
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o <= VERDICT_FULL))
    else $error("verdict code out of range");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(verdict_o)))
    else $error("verdict dropped or changed under stall");

  // clear answers done once the sequencer has passed through EVAL, when no earlier verdict is stalled
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && opcode_i == OP_CLEAR && (!out_valid_o || out_ready_i))
      |=> ##1 (out_valid_o && (verdict_o == VERDICT_DONE)))
    else $error("clear did not answer done");

endmodule

bind national_id_number_validator nidv_sva u_nidv_sva (.*);

`default_nettype wire
